// File: src/rdsn_pkg.sv
// Shared types and constants for the radial deadzone stick normaliser.
`default_nettype none
package rdsn_pkg;

  localparam int DZ_W       = 15;
  localparam int AXIS_W     = 16;
  localparam int FULL_SCALE = 32767;
  localparam int SQ_STAGES  = 24;   // one result bit of the square root per stage
  localparam int DIV_STAGES = 16;   // one quotient bit per stage
  localparam int RAD_W      = 48;   // radicand: sum of squares with 16 fraction bits
  localparam int MAG_W      = 24;   // magnitude with 8 fraction bits
  localparam int DVD_W      = 56;   // rounded dividend
  localparam int DVS_W      = 48;   // doubled divisor

  typedef enum logic [1:0] {
    GRP_LEFT  = 2'd0,
    GRP_RIGHT = 2'd1,
    GRP_TRIG  = 2'd2,
    GRP_NONE  = 2'd3
  } grp_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } rdsn_in_t;

  typedef struct packed {
    logic [1:0]         sensor_group;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
  } rdsn_out_t;

  // Per-beat context carried alongside the arithmetic.
  typedef struct packed {
    logic [1:0]      grp;
    logic            trig;
    logic            neg_x;
    logic            neg_y;
    logic            zero_x;
    logic            zero_y;
    logic [15:0]     ax;
    logic [15:0]     ay;
    logic [DZ_W-1:0] tx;
    logic [DZ_W-1:0] ty;
    logic [DZ_W-1:0] span;
    logic [DZ_W-1:0] dz;
  } rdsn_ctx_t;

endpackage
`default_nettype wire

// File: src/radial_deadzone_stick_normalizer_top.sv
// Top level of the radial deadzone stick normaliser pipeline.
// One beat is accepted per cycle.
// The pipeline depth is set by the 24-stage square root and the 16-stage dividers.
// busy stays low: the pipeline never stalls, as the receiver cannot hold results off.
// Reset (rst, synchronous) clears all valid bits and sets the deadzone to zero.
// Payload registers are not reset.
`default_nettype none
module radial_deadzone_stick_normalizer_top
  import rdsn_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire rdsn_in_t        cmd,
  output logic                 done,
  output rdsn_out_t            result,
  input  wire logic            wr_en,
  input  wire logic [DZ_W-1:0] wr_data
);

  localparam int LATENCY = SQ_STAGES + DIV_STAGES + 7;
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(FULL_SCALE * 256);

  logic [DZ_W-1:0] deadzone;

  // Configuration register: write it only while the pipeline is empty; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= '0;
    end else if (wr_en) begin
      deadzone <= wr_data;
    end
  end

  // The pipeline never holds off a beat.
  assign busy = 1'b0;

  // ---------------- stage 0: capture the beat ----------------
  logic            v0;
  rdsn_in_t        in0;
  logic [DZ_W-1:0] dz0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    in0 <= cmd;
    dz0 <= deadzone;
  end

  // ---------------- stage 1: magnitudes, squares, trigger deadzone ----------------
  logic                 v1;
  rdsn_ctx_t            ctx1, ctx1_next;
  logic [31:0]          sqx, sqy;
  logic [2*DZ_W-1:0]    dz2;

  always_comb begin
    logic [15:0] dx, dy;
    logic        gtx, gty;
    dx  = 16'(in0.raw_x) - {1'b0, dz0};
    dy  = 16'(in0.raw_y) - {1'b0, dz0};
    gtx = $signed({in0.raw_x[15], in0.raw_x}) > $signed({2'b00, dz0});
    gty = $signed({in0.raw_y[15], in0.raw_y}) > $signed({2'b00, dz0});
    ctx1_next.grp   = (in0.opcode == GRP_NONE) ? GRP_LEFT : in0.opcode;
    ctx1_next.trig  = (in0.opcode == GRP_TRIG);
    ctx1_next.ax    = in0.raw_x[15] ? 16'(-in0.raw_x) : 16'(in0.raw_x);
    ctx1_next.ay    = in0.raw_y[15] ? 16'(-in0.raw_y) : 16'(in0.raw_y);
    ctx1_next.tx    = dx[DZ_W-1:0];
    ctx1_next.ty    = dy[DZ_W-1:0];
    ctx1_next.span  = DZ_W'(FULL_SCALE) - dz0;
    ctx1_next.dz    = dz0;
    // Sticks keep the direction sign; triggers are always positive.
    ctx1_next.neg_x = (in0.opcode != GRP_TRIG) && in0.raw_x[15];
    ctx1_next.neg_y = (in0.opcode != GRP_TRIG) && in0.raw_y[15];
    // Drop unused opcodes and triggers at or below the deadzone here.
    case (in0.opcode)
      GRP_TRIG: begin
        ctx1_next.zero_x = !gtx || (dz0 == DZ_W'(FULL_SCALE));
        ctx1_next.zero_y = !gty || (dz0 == DZ_W'(FULL_SCALE));
      end
      GRP_NONE: begin
        ctx1_next.zero_x = 1'b1;
        ctx1_next.zero_y = 1'b1;
      end
      default: begin
        ctx1_next.zero_x = 1'b0;
        ctx1_next.zero_y = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    ctx1 <= ctx1_next;
    sqx  <= 32'($signed(in0.raw_x) * $signed(in0.raw_x));
    sqy  <= 32'($signed(in0.raw_y) * $signed(in0.raw_y));
    dz2  <= dz0 * dz0;
  end

  // ---------------- square root: entry register, then one bit per stage ----------------
  logic             sq_v   [0:SQ_STAGES];
  rdsn_ctx_t        sq_ctx [0:SQ_STAGES];
  logic [RAD_W-1:0] sq_n   [0:SQ_STAGES];
  logic [RAD_W-1:0] sq_res [0:SQ_STAGES];

  rdsn_ctx_t        sq_entry_ctx;
  logic [RAD_W-1:0] sq_entry_rad;

  always_comb begin
    logic [31:0] s;
    s = sqx + sqy;
    sq_entry_ctx = ctx1;
    sq_entry_rad = {s, 16'b0};
    // Stick at or inside the deadzone (zero vector included) or a full deadzone gives zero.
    if (!ctx1.trig && ((s <= 32'(dz2)) || (ctx1.span == '0))) begin
      sq_entry_ctx.zero_x = 1'b1;
      sq_entry_ctx.zero_y = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v1;
  end

  always_ff @(posedge clk) begin
    sq_ctx[0] <= sq_entry_ctx;
    sq_n[0]   <= sq_entry_rad;
    sq_res[0] <= '0;
  end

  for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sqrt
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 * k);
    logic [RAD_W-1:0] trial, n_next, res_next;

    always_comb begin
      trial = sq_res[k-1] + BIT;
      if (sq_n[k-1] >= trial) begin
        n_next   = sq_n[k-1] - trial;
        res_next = (sq_res[k-1] >> 1) + BIT;
      end else begin
        n_next   = sq_n[k-1];
        res_next = sq_res[k-1] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else     sq_v[k] <= sq_v[k-1];
    end

    always_ff @(posedge clk) begin
      sq_ctx[k] <= sq_ctx[k-1];
      sq_n[k]   <= n_next;
      sq_res[k] <= res_next;
    end
  end

  // ---------------- clamp magnitude, subtract deadzone ----------------
  logic             vn;
  rdsn_ctx_t        ctxn;
  logic [MAG_W-1:0] mag, mag_n;

  always_ff @(posedge clk) begin
    if (rst) vn <= 1'b0;
    else     vn <= sq_v[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] m, mc;
    m     = sq_res[SQ_STAGES][MAG_W-1:0];
    mc    = (m > MAG_MAX) ? MAG_MAX : m;
    ctxn  <= sq_ctx[SQ_STAGES];
    mag   <= m;
    mag_n <= mc - {1'b0, sq_ctx[SQ_STAGES].dz, 8'b0};
  end

  // ---------------- products ----------------
  logic             vp;
  rdsn_ctx_t        ctxp;
  logic [39:0]      px, py;
  logic [38:0]      sm;

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else     vp <= vn;
  end

  always_ff @(posedge clk) begin
    ctxp <= ctxn;
    px   <= 40'(mag_n) * 40'(ctxn.ax);
    py   <= 40'(mag_n) * 40'(ctxn.ay);
    sm   <= 39'(ctxn.span) * 39'(mag);
  end

  // ---------------- form rounded dividends and divisor ----------------
  logic             dv_v   [0:DIV_STAGES];
  rdsn_ctx_t        dv_ctx [0:DIV_STAGES];
  logic [DVS_W-1:0] dv_e   [0:DIV_STAGES];
  logic [DVD_W-1:0] dv_rx  [0:DIV_STAGES];
  logic [DVD_W-1:0] dv_ry  [0:DIV_STAGES];
  logic [15:0]      dv_qx  [0:DIV_STAGES];
  logic [15:0]      dv_qy  [0:DIV_STAGES];

  logic [DVD_W-1:0] dvd_x, dvd_y;
  logic [DVS_W-1:0] dvs;

  // (2n + den) / (2 den) rounds n / den to nearest, ties up.
  always_comb begin
    logic [DVD_W-1:0] nx, ny, den;
    logic [DVD_W-1:0] tnx, tny;
    nx  = (DVD_W'(px) << 15) - DVD_W'(px);
    ny  = (DVD_W'(py) << 15) - DVD_W'(py);
    den = DVD_W'(sm) << 8;
    tnx = (DVD_W'(ctxp.tx) << 15) - DVD_W'(ctxp.tx);
    tny = (DVD_W'(ctxp.ty) << 15) - DVD_W'(ctxp.ty);
    if (ctxp.trig) begin
      dvd_x = (tnx << 1) + DVD_W'(ctxp.span);
      dvd_y = (tny << 1) + DVD_W'(ctxp.span);
      dvs   = DVS_W'(ctxp.span) << 1;
    end else begin
      dvd_x = (nx << 1) + den;
      dvd_y = (ny << 1) + den;
      dvs   = DVS_W'(den << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= vp;
  end

  always_ff @(posedge clk) begin
    dv_ctx[0] <= ctxp;
    dv_e[0]   <= dvs;
    dv_rx[0]  <= dvd_x;
    dv_ry[0]  <= dvd_y;
    dv_qx[0]  <= '0;
    dv_qy[0]  <= '0;
  end

  // ---------------- restoring dividers, one quotient bit per stage ----------------
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    localparam int SH = DIV_STAGES - j;
    logic [63:0]      shifted;
    logic             take_x, take_y;

    always_comb begin
      shifted = 64'(dv_e[j-1]) << SH;
      take_x  = 64'(dv_rx[j-1]) >= shifted;
      take_y  = 64'(dv_ry[j-1]) >= shifted;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else     dv_v[j] <= dv_v[j-1];
    end

    always_ff @(posedge clk) begin
      dv_ctx[j] <= dv_ctx[j-1];
      dv_e[j]   <= dv_e[j-1];
      dv_rx[j]  <= take_x ? DVD_W'(64'(dv_rx[j-1]) - shifted) : dv_rx[j-1];
      dv_ry[j]  <= take_y ? DVD_W'(64'(dv_ry[j-1]) - shifted) : dv_ry[j-1];
      dv_qx[j]  <= dv_qx[j-1] | (16'(take_x) << SH);
      dv_qy[j]  <= dv_qy[j-1] | (16'(take_y) << SH);
    end
  end

  // ---------------- saturate, apply sign, present the result beat ----------------
  function automatic logic signed [15:0] finish(input logic [15:0] q, input logic neg,
                                                input logic zero);
    logic [15:0] c;
    c = (q > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : q;
    if (zero)     return '0;
    else if (neg) return -$signed(c);
    else          return $signed(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    result.sensor_group <= dv_ctx[DIV_STAGES].grp;
    result.norm_x <= finish(dv_qx[DIV_STAGES], dv_ctx[DIV_STAGES].neg_x,
                            dv_ctx[DIV_STAGES].zero_x);
    result.norm_y <= finish(dv_qy[DIV_STAGES], dv_ctx[DIV_STAGES].neg_y,
                            dv_ctx[DIV_STAGES].zero_y);
  end

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat did not emerge after the pipeline latency");

  a_group: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.sensor_group != GRP_NONE))
    else $error("unused group code reached the output");

  a_trig_pos: assert property (@(posedge clk) disable iff (rst)
    (done && result.sensor_group == GRP_TRIG) |-> (!result.norm_x[15] && !result.norm_y[15]))
    else $error("negative trigger output");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.norm_x != 16'sh8000 && result.norm_y != 16'sh8000))
    else $error("output outside Q1.15 full scale");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the radial deadzone stick normaliser: random and directed samples, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import rdsn_pkg::*;
();

  localparam int LATENCY   = 47;
  localparam int N_RANDOM  = 1030;
  localparam int MAX_CYC   = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  rdsn_in_t  cmd = '0;
  logic      done;
  rdsn_out_t result;
  logic      wr_en = 1'b0;
  logic [DZ_W-1:0] wr_data = '0;

  radial_deadzone_stick_normalizer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .wr_en(wr_en), .wr_data(wr_data)
  );

  always #2 clk = ~clk;

  rdsn_in_t  pending_samples[$];
  rdsn_out_t expected_norms[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic [DZ_W-1:0] model_dz = '0;
  // Driver controls: gap counters for bursts, and a flag to freeze the feed.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  feed_hold = 1'b1;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  // Divide with rounding to nearest, ties up (values are non-negative).
  function automatic longint unsigned div_round(input longint unsigned n,
                                                input longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned sqrt_floor(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= s) r = b;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] trigger_norm(input int v, input int dz);
    int vc;
    if (v <= dz || dz == FULL_SCALE) return '0;
    vc = v > FULL_SCALE ? FULL_SCALE : v;
    return 16'(div_round(64'(FULL_SCALE) * (vc - dz), FULL_SCALE - dz));
  endfunction

  function automatic logic signed [15:0] stick_norm(input int v, input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned q;
    q = div_round(64'(FULL_SCALE) * num * 64'(v < 0 ? -v : v), den);
    if (q > FULL_SCALE) q = FULL_SCALE;
    return v < 0 ? -16'(q) : 16'(q);
  endfunction

  function automatic rdsn_out_t normalise(input rdsn_in_t s, input int dz);
    rdsn_out_t o;
    longint signed x, y;
    longint unsigned sq, m, mc;
    x = s.raw_x;
    y = s.raw_y;
    o = '0;
    o.sensor_group = s.opcode;
    case (grp_t'(s.opcode))
      GRP_TRIG: begin
        o.norm_x = trigger_norm(int'(x), dz);
        o.norm_y = trigger_norm(int'(y), dz);
      end
      GRP_NONE: o.sensor_group = GRP_LEFT;
      default: begin
        sq = x * x + y * y;
        if (sq > 64'(dz) * dz && dz != FULL_SCALE) begin
          m  = sqrt_floor(sq << 16);
          mc = m > 64'(FULL_SCALE) * 256 ? 64'(FULL_SCALE) * 256 : m;
          o.norm_x = stick_norm(int'(x), mc - 64'(dz) * 256, 256 * 64'(FULL_SCALE - dz) * m);
          o.norm_y = stick_norm(int'(y), mc - 64'(dz) * 256, 256 * 64'(FULL_SCALE - dz) * m);
        end
      end
    endcase
    return o;
  endfunction

  // Driver: feed beats in bursts with random gaps; predict on the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_norms.push_back(normalise(cmd, model_dz));
        void'(pending_samples.pop_front());
      end
      if (start && busy) begin
        // hold the beat until accepted
      end else if (feed_hold || pending_samples.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        cmd   <= pending_samples[0];
        start <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    cycles++;
    if (!rst && done) begin
      if (expected_norms.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        if (result.sensor_group != expected_norms[0].sensor_group)
          report("sensor_group", result.sensor_group, expected_norms[0].sensor_group);
        if (result.norm_x != expected_norms[0].norm_x)
          report("norm_x", result.norm_x, expected_norms[0].norm_x);
        if (result.norm_y != expected_norms[0].norm_y)
          report("norm_y", result.norm_y, expected_norms[0].norm_y);
        void'(expected_norms.pop_front());
      end
    end
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic rdsn_in_t sample(input logic [1:0] op, input int x, input int y);
    rdsn_in_t s;
    s.opcode = op;
    s.raw_x  = 16'(x);
    s.raw_y  = 16'(y);
    return s;
  endfunction

  function automatic int rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 200)) - 100;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Feed out what is queued, hold the feed, drain everything expected, then settle.
  task automatic drain();
    feed_hold = 1'b0;
    while (pending_samples.size() != 0 || start) @(posedge clk);
    feed_hold = 1'b1;
    while (expected_norms.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_deadzone(input logic [DZ_W-1:0] v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
    model_dz = v;
    @(posedge clk);
  endtask

  task automatic run_directed();
    pending_samples.push_back(sample(GRP_LEFT, 0, 0));
    pending_samples.push_back(sample(GRP_LEFT, 32767, 0));
    pending_samples.push_back(sample(GRP_RIGHT, -32768, -32768));
    pending_samples.push_back(sample(GRP_RIGHT, 32767, 32767));
    pending_samples.push_back(sample(GRP_LEFT, 1, -1));
    pending_samples.push_back(sample(GRP_LEFT, -32768, 32767));
    pending_samples.push_back(sample(GRP_RIGHT, 3000, -4000));
    pending_samples.push_back(sample(GRP_TRIG, 32767, -32768));
    pending_samples.push_back(sample(GRP_TRIG, 0, 1));
    pending_samples.push_back(sample(GRP_TRIG, -1, 16384));
    pending_samples.push_back(sample(GRP_NONE, 12345, -12345));
    pending_samples.push_back(sample(GRP_NONE, -32768, 32767));
  endtask

  initial begin
    logic [DZ_W-1:0] dz_set[6];
    dz_set = '{15'd0, 15'd8000, 15'd32767, 15'd1, 15'd32766, 15'd3000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dz_set[p]) begin
      write_deadzone(dz_set[p]);
      run_directed();
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        // mostly random opcodes, triggers around each deadzone edge now and then
        if ($urandom_range(0, 7) == 0)
          pending_samples.push_back(sample(GRP_TRIG, int'(model_dz) + int'($urandom_range(0, 2)) - 1,
                                           rand_axis()));
        else
          pending_samples.push_back(sample(2'($urandom_range(0, 3)), rand_axis(), rand_axis()));
        if (i == 80) begin
          // pause the feed until everything in flight has come back
          feed_hold = 1'b0;
          while (pending_samples.size() != 0 || start) @(posedge clk);
          feed_hold = 1'b1;
          while (expected_norms.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/rdsn_pkg.sv
src/radial_deadzone_stick_normalizer_top.sv
verif/tb_top.sv
